[design/aclp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aclp_pkg
// Shared constants, types and the tag lookup for the ASCII command line parser.
// ----------------------------------------------------------------------------
package aclp_pkg;

   localparam int MAX_LINE    = 40;
   localparam int LINE_ADDR_W = $clog2(MAX_LINE);
   localparam int LINE_LEN_W  = $clog2(MAX_LINE + 1);

   typedef logic [7:0] char_type;
   typedef logic [1:0] kind_type;
   typedef logic [7:0] value_type;

   localparam char_type CH_LF = 8'd10;
   localparam char_type CH_CR = 8'd13;
   localparam char_type CH_EQ = 8'd61;
   localparam char_type CH_0  = 8'd48;
   localparam char_type CH_9  = 8'd57;

   localparam kind_type KIND_WAKE = 2'd0;
   localparam kind_type KIND_CMD  = 2'd1;
   localparam kind_type KIND_DONE = 2'd2;

   localparam logic [11:0] VAL_MAX = 12'd255;

   // Length of the tag that belongs to a kind.
   function automatic logic [2:0] tag_len(input kind_type kind);
      logic [2:0] len;
      len = (kind == KIND_CMD) ? 3'd3 : 3'd4;
      return len;
   endfunction

   // Expected tag character at a given position for a kind.
   function automatic char_type tag_char(input kind_type kind, input logic [1:0] idx);
      char_type ch;
      ch = 8'h00;
      case (kind)
         KIND_WAKE: begin
            case (idx)
               2'd0:    ch = "w";
               2'd1:    ch = "a";
               2'd2:    ch = "k";
               default: ch = "e";
            endcase
         end
         KIND_CMD: begin
            case (idx)
               2'd0:    ch = "c";
               2'd1:    ch = "m";
               2'd2:    ch = "d";
               default: ch = CH_EQ;
            endcase
         end
         KIND_DONE: begin
            case (idx)
               2'd0:    ch = "d";
               2'd1:    ch = "o";
               2'd2:    ch = "n";
               default: ch = "e";
            endcase
         end
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

[design/ascii_command_line_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_command_line_parser
// Gathers received characters into a line and decodes wake, cmd=N and done=N.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload                        Handshake
// req      in         req_rx_byte (8)                req_valid / req_ready
// rsp      out        rsp_event_kind (2),            rsp_valid / rsp_ready
//                     rsp_event_value (8)
//
// A character other than LF is written to the line RAM while the line has room.
// An LF ending a line of stored bytes (after CR removal) starts a walk:
// the walk reads one byte a cycle from the single RAM port and feeds it to a
// shared compare and multiply-by-ten unit. An empty or overflowed line gives no walk and no event.
// Reset clears the line length, the overflow flag and the output valid flag.
// A walk that ends while the previous event is unread holds until it is taken.
// ----------------------------------------------------------------------------
module ascii_command_line_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  aclp_pkg::char_type   req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output aclp_pkg::kind_type   rsp_event_kind,
   output aclp_pkg::value_type  rsp_event_value
);

   import aclp_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [LINE_LEN_W-1:0]  length_ff, length_in;
   logic                   overflow_ff, overflow_in;
   logic                   last_cr_ff, last_cr_in;
   logic [LINE_LEN_W-1:0]  n_ff, n_in;
   logic [LINE_LEN_W-1:0]  rd_idx_ff, rd_idx_in;
   logic                   dv_ff, dv_in;
   logic [LINE_ADDR_W-1:0] pos_ff, pos_in;
   kind_type               kind_ff, kind_in;
   logic                   ok_ff, ok_in;
   value_type              acc_ff, acc_in;
   logic [1:0]             digits_ff, digits_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   kind_type               rsp_kind_ff, rsp_kind_in;
   value_type              rsp_value_ff, rsp_value_in;

   logic                   req_fire;
   logic                   ram_we;
   logic [LINE_ADDR_W-1:0] ram_addr;
   char_type               ram_rd;
   logic [2:0]             tlen;
   logic [11:0]            next_val;
   logic                   hit;
   logic [LINE_LEN_W-1:0]  eff_len;

   aclp_ram #(
      .WIDTH (8),
      .DEPTH (MAX_LINE)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (req_rx_byte),
      .rd_data (ram_rd)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign eff_len   = length_ff - {{(LINE_LEN_W-1){1'b0}}, last_cr_ff};
   assign tlen      = tag_len(kind_ff);
   // The shared unit: acc * 10 + digit, built from two shifts and two adds.
   assign next_val  = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                      + {8'h00, ram_rd[3:0]};
   assign hit       = ok_ff && ((kind_ff == KIND_WAKE)
                                ? (n_ff == LINE_LEN_W'(4)) : (digits_ff != 2'd0));

   always_comb begin
      state_in     = state_ff;
      length_in    = length_ff;
      overflow_in  = overflow_ff;
      last_cr_in   = last_cr_ff;
      n_in         = n_ff;
      rd_idx_in    = rd_idx_ff;
      dv_in        = 1'b0;
      pos_in       = pos_ff;
      kind_in      = kind_ff;
      ok_in        = ok_ff;
      acc_in       = acc_ff;
      digits_in    = digits_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      ram_we       = 1'b0;
      ram_addr     = length_ff[LINE_ADDR_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_rx_byte == CH_LF) begin
                  length_in   = '0;
                  overflow_in = 1'b0;
                  last_cr_in  = 1'b0;
                  n_in        = eff_len;
                  rd_idx_in   = '0;
                  if (!overflow_ff && eff_len != '0) begin
                     state_in = ST_WALK;
                  end
               end else if (!overflow_ff) begin
                  if (length_ff == LINE_LEN_W'(MAX_LINE)) begin
                     overflow_in = 1'b1;
                  end else begin
                     ram_we     = 1'b1;
                     length_in  = length_ff + LINE_LEN_W'(1);
                     last_cr_in = (req_rx_byte == CH_CR);
                  end
               end
            end
         end

         ST_WALK: begin
            ram_addr = rd_idx_ff[LINE_ADDR_W-1:0];
            if (rd_idx_ff < n_ff) begin
               dv_in     = 1'b1;
               pos_in    = rd_idx_ff[LINE_ADDR_W-1:0];
               rd_idx_in = rd_idx_ff + LINE_LEN_W'(1);
            end else if (!dv_ff) begin
               state_in = ST_DONE;
            end

            // Check the byte read in the previous cycle.
            if (dv_ff) begin
               if (pos_ff == '0) begin
                  acc_in    = '0;
                  digits_in = 2'd0;
                  ok_in     = 1'b1;
                  case (ram_rd)
                     "w":     kind_in = KIND_WAKE;
                     "c":     kind_in = KIND_CMD;
                     "d":     kind_in = KIND_DONE;
                     default: begin
                        kind_in = KIND_WAKE;
                        ok_in   = 1'b0;
                     end
                  endcase
               end else if (ok_ff) begin
                  if (pos_ff < LINE_ADDR_W'(tlen)) begin
                     ok_in = (ram_rd == tag_char(kind_ff, pos_ff[1:0]));
                  end else if (pos_ff == LINE_ADDR_W'(tlen)) begin
                     ok_in = (kind_ff != KIND_WAKE) && (ram_rd == CH_EQ);
                  end else if (ram_rd inside {[CH_0:CH_9]} && digits_ff != 2'd3
                               && next_val <= VAL_MAX) begin
                     acc_in    = next_val[7:0];
                     digits_in = digits_ff + 2'd1;
                  end else begin
                     ok_in = 1'b0;
                  end
               end
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = hit;
               rsp_kind_in  = kind_ff;
               rsp_value_in = (kind_ff == KIND_WAKE) ? '0 : acc_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         length_ff    <= '0;
         overflow_ff  <= 1'b0;
         last_cr_ff   <= 1'b0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         overflow_ff  <= overflow_in;
         last_cr_ff   <= last_cr_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      rd_idx_ff    <= rd_idx_in;
      pos_ff       <= pos_in;
      kind_ff      <= kind_in;
      ok_ff        <= ok_in;
      acc_ff       <= acc_in;
      digits_ff    <= digits_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = rsp_kind_ff;
   assign rsp_event_value = rsp_value_ff;

`ifndef SYNTHESIS
   // The stored length never runs past the line store.
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      length_ff <= LINE_LEN_W'(MAX_LINE))
      else $error("line length beyond store");

   // An overflowed line always has a full store behind it.
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> (length_ff == LINE_LEN_W'(MAX_LINE)))
      else $error("overflow flag without full store");

   // An accepted LF starts the next line empty and clean.
   a_lf_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_rx_byte == CH_LF) |=> (length_ff == '0 && !overflow_ff))
      else $error("LF did not clear the line");

   // A wake event carries a zero value, and no event has an unused kind.
   a_wake_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_kind == KIND_WAKE) |-> (rsp_event_value == '0))
      else $error("wake event with non-zero value");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_event_kind <= KIND_DONE))
      else $error("unused event kind");

   // Nothing is in flight from the RAM once the walk has finished.
   a_walk_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (!dv_ff && rd_idx_ff == n_ff))
      else $error("walk ended with bytes outstanding");
`endif

endmodule

[design/aclp_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aclp_ram
// Single-port RAM with one address per cycle and a registered read.
// ----------------------------------------------------------------------------
module aclp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 40
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ASCII command line parser. A short list of
// hand-written lines covers the edge cases, then random lines (mostly well
// formed commands, the rest corrupted, noise, overlong or empty) are streamed under
// changing idle patterns. A line model, or the fixed event of a directed row,
// predicts every event, and each event from the block is checked against it.
// ----------------------------------------------------------------------------
module tb;
   import aclp_pkg::*;

   typedef struct packed {
      kind_type  kind;
      value_type value;
   } line_event_type;

   // One directed line: head, fill byte repeated fill_n times, tail, optional
   // CR, then LF. Where fixed is set, the event in the row is the expectation.
   typedef struct {
      string     head;
      char_type  fill;
      int        fill_n;
      string     tail;
      bit        cr;
      bit        fixed;
      bit        has_ev;
      kind_type  kind;
      value_type value;
   } line_row_type;

   localparam int SCRIPT_ROWS = 22;

   line_row_type script_rows [SCRIPT_ROWS] = '{
      '{"",         8'h00, 0,  "",     1'b0, 1'b1, 1'b0, KIND_WAKE, 8'd0},
      '{"",         8'h00, 0,  "",     1'b1, 1'b1, 1'b0, KIND_WAKE, 8'd0},
      '{"wake",     8'h00, 0,  "",     1'b0, 1'b1, 1'b1, KIND_WAKE, 8'd0},
      '{"wake",     8'h00, 0,  "",     1'b1, 1'b1, 1'b1, KIND_WAKE, 8'd0},
      '{"cmd=0",    8'h00, 0,  "",     1'b0, 1'b1, 1'b1, KIND_CMD,  8'd0},
      '{"cmd=255",  8'h00, 0,  "",     1'b0, 1'b1, 1'b1, KIND_CMD,  8'd255},
      '{"done=000", 8'h00, 0,  "",     1'b1, 1'b1, 1'b1, KIND_DONE, 8'd0},
      '{"done=255", 8'h00, 0,  "",     1'b0, 1'b1, 1'b1, KIND_DONE, 8'd255},
      '{"cmd=256",  8'h00, 0,  "",     1'b0, 1'b1, 1'b0, KIND_WAKE, 8'd0},
      '{"cmd=0000", 8'h00, 0,  "",     1'b0, 1'b1, 1'b0, KIND_WAKE, 8'd0},
      '{"cmd=",     8'h00, 0,  "",     1'b0, 1'b1, 1'b0, KIND_WAKE, 8'd0},
      '{"cmd",      8'h00, 0,  "",     1'b0, 1'b1, 1'b0, KIND_WAKE, 8'd0},
      '{"done=",    CH_CR, 1,  "7",    1'b0, 1'b1, 1'b0, KIND_WAKE, 8'd0},
      '{"cmd=5",    CH_CR, 1,  "",     1'b1, 1'b1, 1'b0, KIND_WAKE, 8'd0},
      '{"wakeX",    8'h00, 0,  "",     1'b0, 1'b1, 1'b0, KIND_WAKE, 8'd0},
      '{"cmd=1",    8'hFF, 1,  "",     1'b0, 1'b1, 1'b0, KIND_WAKE, 8'd0},
      '{"",         8'h00, 1,  "wake", 1'b0, 1'b1, 1'b0, KIND_WAKE, 8'd0},
      '{"",         "a",   41, "",     1'b0, 1'b1, 1'b0, KIND_WAKE, 8'd0},
      '{"cmd=7",    8'h00, 0,  "",     1'b0, 1'b0, 1'b0, KIND_WAKE, 8'd0},
      '{"",         "z",   40, "",     1'b0, 1'b0, 1'b0, KIND_WAKE, 8'd0},
      '{"",         "q",   39, "",     1'b1, 1'b0, 1'b0, KIND_WAKE, 8'd0},
      '{"done=09",  8'h00, 0,  "",     1'b1, 1'b0, 1'b0, KIND_WAKE, 8'd0}
   };

   logic      clock     = 1'b0;
   logic      reset     = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   char_type  req_rx_byte = 8'h00;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   kind_type  rsp_event_kind;
   value_type rsp_event_value;

   // Line model state.
   char_type       line_buf [MAX_LINE];
   int             line_fill = 0;
   bit             line_lost = 1'b0;
   line_event_type pending_events [$];

   char_type    line_q [$];
   int          bytes_taken      = 0;
   int          errors           = 0;
   int          sender_idle_pct  = 0;
   int          recv_idle_pct    = 0;
   bit          hold_go          = 1'b0;

   ascii_command_line_parser dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_event_value (rsp_event_value)
   );

   always #6 clock = ~clock;

   function automatic bit has_prefix(input string tag);
      for (int i = 0; i < tag.len(); i++) begin
         if (line_buf[i] != char_type'(tag[i])) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Decodes the first n stored bytes into an event.
   function automatic bit decode_line(input int n, output kind_type kind,
                                      output value_type value);
      int tag_end;
      int acc;
      int digits;
      kind  = KIND_WAKE;
      value = 8'd0;
      if (n == 4 && has_prefix("wake")) return 1'b1;
      if (n >= 3 && has_prefix("cmd")) begin
         kind    = KIND_CMD;
         tag_end = 3;
      end else if (n >= 4 && has_prefix("done")) begin
         kind    = KIND_DONE;
         tag_end = 4;
      end else begin
         return 1'b0;
      end
      if (n < tag_end + 2 || line_buf[tag_end] != CH_EQ) return 1'b0;
      acc    = 0;
      digits = 0;
      for (int i = tag_end + 1; i < n; i++) begin
         if (line_buf[i] < CH_0 || line_buf[i] > CH_9) return 1'b0;
         acc = acc * 10 + int'(line_buf[i] - CH_0);
         digits++;
         if (digits > 3 || acc > int'(VAL_MAX)) return 1'b0;
      end
      value = value_type'(acc);
      return 1'b1;
   endfunction

   // Advances the line model by one accepted request.
   function automatic void record_char(input char_type ch, input bit fixed,
                                       input line_event_type fixed_ev,
                                       input bit fixed_has);
      int        n;
      kind_type  kind;
      value_type value;
      if (ch == CH_LF) begin
         if (!line_lost) begin
            n = line_fill;
            if (n > 0 && line_buf[n - 1] == CH_CR) n--;
            if (fixed) begin
               if (fixed_has) pending_events.push_back(fixed_ev);
            end else if (decode_line(n, kind, value)) begin
               pending_events.push_back(line_event_type'{kind, value});
            end
         end
         line_fill = 0;
         line_lost = 1'b0;
      end else if (!line_lost) begin
         if (line_fill >= MAX_LINE) begin
            line_lost = 1'b1;
         end else begin
            line_buf[line_fill] = ch;
            line_fill++;
         end
      end
   endfunction

   task automatic send_byte(input char_type ch, input bit fixed = 1'b0,
                            input line_event_type fixed_ev = '0,
                            input bit fixed_has = 1'b0);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= ch;
      do @(posedge clock); while (!req_ready);
      // Bytes swallowed by an overflowed line do not count as stimulus.
      if (ch == CH_LF || !line_lost) bytes_taken++;
      record_char(ch, fixed, fixed_ev, fixed_has);
   endtask

   task automatic send_line();
      foreach (line_q[i]) send_byte(line_q[i]);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   function automatic void push_text(input string s);
      for (int i = 0; i < s.len(); i++) line_q.push_back(char_type'(s[i]));
   endfunction

   function automatic void push_number(input int val, input int width);
      int scale;
      scale = 1;
      for (int i = 1; i < width; i++) scale *= 10;
      for (int i = 0; i < width; i++) begin
         line_q.push_back(CH_0 + char_type'((val / scale) % 10));
         scale /= 10;
      end
   endfunction

   function automatic int pick_value();
      if ($urandom_range(0, 9) == 0) return ($urandom_range(0, 1) == 1) ? 255 : 0;
      return $urandom_range(0, 255);
   endfunction

   // Builds a random line ending in LF. With clean set it is always well formed.
   function automatic void build_random_line(input bit clean);
      int pick;
      int val;
      int width;
      int cut;
      line_q.delete();
      pick = clean ? $urandom_range(0, 59) : $urandom_range(0, 99);
      if (pick < 80) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: push_text("cmd=");
            4, 5, 6, 7: push_text("done=");
            default:    push_text("wake");
         endcase
         if (line_q[0] != "w") begin
            val   = pick_value();
            width = (val >= 100) ? 3 : (val >= 10) ? 2 : 1;
            width = $urandom_range(width, 3);
            if (pick >= 60 && $urandom_range(0, 4) == 0) push_number($urandom_range(256, 999), 3);
            else if (pick >= 60 && $urandom_range(0, 3) == 0) push_number(val, 4);
            else push_number(val, width);
         end
         if (pick >= 60) begin
            case ($urandom_range(0, 2))
               0: begin
                  cut = $urandom_range(0, line_q.size() - 1);
                  line_q[cut] = char_type'($urandom_range(0, 255));
                  if (line_q[cut] == CH_LF) line_q[cut] = CH_CR;
               end
               1: begin
                  cut = $urandom_range(0, line_q.size() - 1);
                  while (line_q.size() > cut) void'(line_q.pop_back());
               end
               default: line_q.push_back(char_type'($urandom_range(32, 126)));
            endcase
         end
      end else if (pick < 90) begin
         repeat ($urandom_range(0, 12)) line_q.push_back(char_type'($urandom_range(0, 255)));
      end else if (pick < 95) begin
         if ($urandom_range(0, 1) == 1) push_text("cmd=1");
         repeat ($urandom_range(34, 44)) line_q.push_back(char_type'($urandom_range(33, 126)));
      end
      if ($urandom_range(0, 3) == 0) line_q.push_back(CH_CR);
      line_q.push_back(CH_LF);
   endfunction

   task automatic run_random(input int send_pct, input int recv_pct, input int target);
      int start;
      sender_idle_pct = send_pct;
      recv_idle_pct   = recv_pct;
      start           = bytes_taken;
      while (bytes_taken - start < target) begin
         build_random_line(1'b0);
         send_line();
      end
   endtask

   task automatic run_script();
      line_row_type row;
      for (int r = 0; r < SCRIPT_ROWS; r++) begin
         row = script_rows[r];
         line_q.delete();
         push_text(row.head);
         repeat (row.fill_n) line_q.push_back(row.fill);
         push_text(row.tail);
         if (row.cr) line_q.push_back(CH_CR);
         send_line();
         send_byte(CH_LF, row.fixed, line_event_type'{row.kind, row.value}, row.has_ev);
      end
   endtask

   task automatic check_event();
      line_event_type want;
      if (pending_events.size() == 0) begin
         $error("event with none expected: event_kind %0d, event_value %0d",
                rsp_event_kind, rsp_event_value);
         errors++;
      end else begin
         want = pending_events.pop_front();
         if (rsp_event_kind !== want.kind) begin
            $error("event_kind: expected %0d, got %0d", want.kind, rsp_event_kind);
            errors++;
         end
         if (rsp_event_value !== want.value) begin
            $error("event_value: expected %0d, got %0d", want.value, rsp_event_value);
            errors++;
         end
      end
   endtask

   // Result side: checks each event and paces rsp_ready, with one long hold-off.
   int hold_left  = 0;
   bit hold_taken = 1'b0;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_event();
      if (hold_go && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = 500;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      sender_idle_pct = 6;
      recv_idle_pct   = 88;
      run_script();

      run_random(6, 88, 525);
      wait_drain();
      run_random(88, 6, 265);
      // Let every outstanding event come back before carrying on.
      wait_drain();
      run_random(88, 6, 265);
      wait_drain();

      run_random(0, 0, 240);
      // Keep offering commands while the result side is held off, so the
      // block fills and has to stall its request side.
      hold_go = 1'b1;
      repeat (15) begin
         build_random_line(1'b1);
         send_line();
      end
      run_random(0, 0, 240);
      wait_drain();

      if (errors == 0 && pending_events.size() == 0) begin
         $display("ascii_command_line_parser regression: pass");
      end else begin
         $display("ascii_command_line_parser regression: fail");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("ascii_command_line_parser regression: fail");
      $finish;
   end

endmodule
